/* rtl/aabb_cr_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_cr_pkg: shared types and helpers for the box collision resolver
// Coordinate widths, hit side codes, request/result structs, and the
// extend and saturate helpers for the widened overlap arithmetic.
// ----------------------------------------------------------------------------
package aabb_cr_pkg;

    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 4;
    // overlap and moved coordinates: coord + size - coord, plus one for +/- pen
    localparam int OV_BITS    = COORD_BITS + 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic signed [OV_BITS-1:0]    t_ov;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_TOP    = 3'd1,
        SIDE_BOTTOM = 3'd2,
        SIDE_LEFT   = 3'd3,
        SIDE_RIGHT  = 3'd4
    } t_side;

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_size  first_w;
        t_size  first_h;
        t_coord second_x;
        t_coord second_y;
        t_size  second_w;
        t_size  second_h;
        logic   either_rigid;
        logic   first_movable;
        logic   second_movable;
    } t_req;

    typedef struct packed {
        t_side  hit_side;
        t_coord first_new_x;
        t_coord first_new_y;
        t_coord second_new_x;
        t_coord second_new_y;
        logic   clear_first_speed_x;
        logic   clear_first_speed_y;
        logic   set_first_grounded;
    } t_res;

    function automatic t_ov ext_coord(input t_coord v);
        return t_ov'({{(OV_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
    endfunction

    function automatic t_ov ext_size(input t_size v);
        return t_ov'({{(OV_BITS-SIZE_BITS){1'b0}}, v});
    endfunction

    function automatic t_coord sat_coord(input t_ov v);
        logic in_range;
        in_range = (v[OV_BITS-1:COORD_BITS-1] == {(OV_BITS-COORD_BITS+1){v[OV_BITS-1]}});
        if (in_range) begin
            return t_coord'(v[COORD_BITS-1:0]);
        end else if (v[OV_BITS-1]) begin
            return t_coord'({1'b1, {(COORD_BITS-1){1'b0}}});
        end else begin
            return t_coord'({1'b0, {(COORD_BITS-1){1'b1}}});
        end
    endfunction

endpackage

/* rtl/aabb_cr_in_if.sv */
// ----------------------------------------------------------------------------
// aabb_cr_in_if: request channel of the box collision resolver
// Valid/ready handshake carrying one pair of boxes and their body flags.
// ----------------------------------------------------------------------------
interface aabb_cr_in_if import aabb_cr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord first_x;
    t_coord first_y;
    t_size  first_w;
    t_size  first_h;
    t_coord second_x;
    t_coord second_y;
    t_size  second_w;
    t_size  second_h;
    logic   either_rigid;
    logic   first_movable;
    logic   second_movable;

    modport source (
        output valid, first_x, first_y, first_w, first_h,
               second_x, second_y, second_w, second_h,
               either_rigid, first_movable, second_movable,
        input  ready
    );

    modport sink (
        input  valid, first_x, first_y, first_w, first_h,
               second_x, second_y, second_w, second_h,
               either_rigid, first_movable, second_movable,
        output ready
    );
endinterface

/* rtl/aabb_cr_out_if.sv */
// ----------------------------------------------------------------------------
// aabb_cr_out_if: result channel of the box collision resolver
// Valid/ready handshake carrying hit side, corrected origins and flags.
// ----------------------------------------------------------------------------
interface aabb_cr_out_if import aabb_cr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  hit_side;
    t_coord      first_new_x;
    t_coord      first_new_y;
    t_coord      second_new_x;
    t_coord      second_new_y;
    logic        clear_first_speed_x;
    logic        clear_first_speed_y;
    logic        set_first_grounded;

    modport source (
        output valid, hit_side, first_new_x, first_new_y, second_new_x,
               second_new_y, clear_first_speed_x, clear_first_speed_y,
               set_first_grounded,
        input  ready
    );

    modport sink (
        input  valid, hit_side, first_new_x, first_new_y, second_new_x,
               second_new_y, clear_first_speed_x, clear_first_speed_y,
               set_first_grounded,
        output ready
    );
endinterface

/* rtl/aabb_cr_resolve.sv */
// ----------------------------------------------------------------------------
// aabb_cr_resolve: overlap, hit side and position correction for one pair
// Computes the four overlaps, picks the smallest (top, bottom, left, right
// on ties), then pushes the boxes apart with saturation.
// ----------------------------------------------------------------------------
module aabb_cr_resolve import aabb_cr_pkg::*; (
    input  t_req i_req,
    output t_res o_res
);

    t_ov   ax, ay, bx, by;
    t_ov   ov_left, ov_right, ov_top, ov_bottom;
    t_ov   pen, half;
    t_ov   nax, nay, nbx, nby;
    t_side side;
    logic  apart;
    logic  resolve;

    always_comb begin
        ax = ext_coord(i_req.first_x);
        ay = ext_coord(i_req.first_y);
        bx = ext_coord(i_req.second_x);
        by = ext_coord(i_req.second_y);

        ov_left   = ax + ext_size(i_req.first_w)  - bx;
        ov_right  = bx + ext_size(i_req.second_w) - ax;
        ov_bottom = ay + ext_size(i_req.first_h)  - by;
        ov_top    = by + ext_size(i_req.second_h) - ay;

        // touching edges give zero overlap and count as apart
        apart = (ov_left <= 0) || (ov_right <= 0) || (ov_bottom <= 0) || (ov_top <= 0);

        pen  = ov_top;
        side = SIDE_TOP;
        if (ov_bottom < pen) begin
            pen  = ov_bottom;
            side = SIDE_BOTTOM;
        end
        if (ov_left < pen) begin
            pen  = ov_left;
            side = SIDE_LEFT;
        end
        if (ov_right < pen) begin
            pen  = ov_right;
            side = SIDE_RIGHT;
        end
        // pen > 0 whenever it is used, so the shift truncates
        half = pen >>> 1;

        resolve = !apart && i_req.either_rigid &&
                  (i_req.first_movable || i_req.second_movable);

        nax = ax;
        nay = ay;
        nbx = bx;
        nby = by;
        o_res.clear_first_speed_x = 1'b0;
        o_res.clear_first_speed_y = 1'b0;
        o_res.set_first_grounded  = 1'b0;

        if (resolve) begin
            case (side)
                SIDE_BOTTOM: begin
                    o_res.set_first_grounded = 1'b1;
                    if (i_req.first_movable) begin
                        o_res.clear_first_speed_y = 1'b1;
                        nay = ay - pen;
                    end
                    if (i_req.second_movable) nby = by + half;
                end
                SIDE_TOP: begin
                    if (i_req.first_movable) begin
                        o_res.clear_first_speed_y = 1'b1;
                        nay = ay + pen;
                    end
                    if (i_req.second_movable) nby = by - half;
                end
                SIDE_LEFT: begin
                    if (i_req.first_movable) begin
                        o_res.clear_first_speed_x = 1'b1;
                        nax = ax - pen;
                    end
                    if (i_req.second_movable) nbx = bx + half;
                end
                default: begin
                    if (i_req.first_movable) begin
                        o_res.clear_first_speed_x = 1'b1;
                        nax = ax + pen;
                    end
                    if (i_req.second_movable) nbx = bx - half;
                end
            endcase
        end

        o_res.hit_side     = apart ? SIDE_NONE : side;
        o_res.first_new_x  = sat_coord(nax);
        o_res.first_new_y  = sat_coord(nay);
        o_res.second_new_x = sat_coord(nbx);
        o_res.second_new_y = sat_coord(nby);
    end

endmodule

/* rtl/aabb_collision_resolve.sv */
// ----------------------------------------------------------------------------
// aabb_collision_resolve: minimum-penetration resolution of two boxes
// Top level: request register, resolve logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  - valid/ready request channel, one box pair per request.
//   o_res  - valid/ready result channel, exactly one result per request.
//   A request taken is held in the request register, resolved combinationally
//   from it and captured in the result register once that register is free
//   or its result is taken; o_res.valid is high after the capture.
//   Throughput is one request per cycle while o_res.ready is high: the request
//   register and the result register form a two-entry pipeline, and a new
//   request is taken while a result waits if the request register is empty.
//   The critical path is the overlap add, the three-step minimum compare and
//   the position add with saturation.
//   When o_res.ready stays low, the result holds and the pipeline fills; after
//   two requests are held, i_req.ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous) empties both registers; no results are
//   pending afterwards. The block keeps no state between requests.
// ----------------------------------------------------------------------------
module aabb_collision_resolve import aabb_cr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aabb_cr_in_if.sink    i_req,
    aabb_cr_out_if.source o_res
);

    t_req r_req;
    logic r_req_valid;
    t_res n_res;
    t_res r_res;
    logic r_res_valid;
    logic res_load;

    assign res_load    = r_req_valid && (!r_res_valid || o_res.ready);
    assign i_req.ready = !r_req_valid || res_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.first_x        <= i_req.first_x;
            r_req.first_y        <= i_req.first_y;
            r_req.first_w        <= i_req.first_w;
            r_req.first_h        <= i_req.first_h;
            r_req.second_x       <= i_req.second_x;
            r_req.second_y       <= i_req.second_y;
            r_req.second_w       <= i_req.second_w;
            r_req.second_h       <= i_req.second_h;
            r_req.either_rigid   <= i_req.either_rigid;
            r_req.first_movable  <= i_req.first_movable;
            r_req.second_movable <= i_req.second_movable;
        end
    end

    aabb_cr_resolve u_resolve (
        .i_req (r_req),
        .o_res (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (!r_res_valid || o_res.ready) begin
            r_res_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid               = r_res_valid;
    assign o_res.hit_side            = r_res.hit_side;
    assign o_res.first_new_x         = r_res.first_new_x;
    assign o_res.first_new_y         = r_res.first_new_y;
    assign o_res.second_new_x        = r_res.second_new_x;
    assign o_res.second_new_y        = r_res.second_new_y;
    assign o_res.clear_first_speed_x = r_res.clear_first_speed_x;
    assign o_res.clear_first_speed_y = r_res.clear_first_speed_y;
    assign o_res.set_first_grounded  = r_res.set_first_grounded;

`ifndef SYNTHESIS
    a_none_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_res.hit_side == SIDE_NONE) |->
        (!o_res.clear_first_speed_x && !o_res.clear_first_speed_y &&
         !o_res.set_first_grounded))
        else $error("flags set without a hit");

    a_grounded_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.set_first_grounded) |-> (r_res.hit_side == SIDE_BOTTOM))
        else $error("grounded without a bottom hit");

    a_one_axis_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.clear_first_speed_x && o_res.clear_first_speed_y))
        else $error("speed cleared on both axes");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && r_res_valid && !o_res.ready) |-> !i_req.ready)
        else $error("request taken while pipeline is full");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_req_valid)
        else $error("accepted request lost");
`endif

endmodule
